/* sv/slt_pkg.sv */
package slt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MASK_BYTES = 8;

  localparam logic [4:0] REMOVED_MAX = 5'd31;
  localparam logic [15:0] REMAINING_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_GET    = 2'd1,
    OP_PRUNE  = 2'd2,
    OP_FLUSH  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] requester_clock_identity;
    logic [15:0] requester_port_number;
    logic [31:0] return_address;
    logic [63:0] event_mask;
    logic [15:0] lease_seconds;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] granted_mask;
    logic [15:0] remaining_seconds;
    logic [4:0]  removed_count;
  } rsp_t;

  // token walking down the row of cells
  typedef struct packed {
    logic        active;
    logic        found;
    logic        free_found;
    logic [4:0]  removed;
    logic [63:0] hit_mask;
    logic [15:0] hit_remaining;
  } tok_t;

endpackage

/* sv/slt_req_if.sv */
interface slt_req_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/slt_rsp_if.sv */
interface slt_rsp_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/subscription_lease_table.sv */
// a request is registered and launched, then a token walks the row of cells, one cell
//   per cycle; the finish register takes its result and the response moves to the
//   output register when the output is free
// the next request is taken as soon as the previous response sits in the output register
// reset: synchronous, active high; empties the table and drops any request in flight
module subscription_lease_table import slt_pkg::*; #(
  parameter int TableEntries = TABLE_ENTRIES,
  parameter int MaskBytes = MASK_BYTES
) (
  input  logic clk,
  input  logic rst,
  slt_req_if.sink   req,
  slt_rsp_if.source rsp
);

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [63:0] MaskBits =
    (MaskBytes >= 8) ? {64{1'b1}} : ((64'd1 << (MaskBytes * 8)) - 64'd1);

  logic        busy;
  req_t        cmd;
  req_t        req_masked;
  logic [32:0] lease_end;
  tok_t        chain [TableEntries+1];
  logic [IdxW-1:0] fidx [TableEntries+1];

  logic        launch;
  tok_t        launch_tok;
  logic        pending;
  rsp_t        pend_rsp;
  logic        ins_pending;
  logic [IdxW-1:0] ins_idx;
  logic        rsp_valid;
  rsp_t        rsp_data;
  logic        out_free;
  logic        move;
  logic        ins_en;
  logic        accept;
  tok_t        tok_end;
  rsp_t        fin_rsp;
  logic        fin_insert;

  assign req.ready = !busy && !rst;
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign move      = pending && out_free;
  assign ins_en    = move && ins_pending;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign tok_end   = chain[TableEntries];

  always_comb begin
    req_masked            = req.data;
    req_masked.event_mask = req.data.event_mask & MaskBits;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= req_masked;
      lease_end <= {1'b0, req.data.now_seconds} + {17'd0, req.data.lease_seconds};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept;
    end
  end

  always_comb begin
    launch_tok        = '0;
    launch_tok.active = launch;
  end

  assign chain[0] = launch_tok;
  assign fidx[0]  = '0;

  genvar g;
  generate
    for (g = 0; g < TableEntries; g++) begin : g_cell
      slt_cell #(
        .IdxW (IdxW),
        .Index(g)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .lease_end   (lease_end),
        .tok_in      (chain[g]),
        .free_idx_in (fidx[g]),
        .tok_out     (chain[g+1]),
        .free_idx_out(fidx[g+1]),
        .ins_en      (ins_en),
        .ins_idx     (ins_idx)
      );
    end
  endgenerate

  always_comb begin
    fin_rsp    = '0;
    fin_insert = 1'b0;
    case (cmd.opcode)
      OP_UPDATE: begin
        if (cmd.event_mask == 64'd0) begin
          fin_rsp.status = tok_end.found ? ST_REMOVED : ST_NO_ENTRY;
        end else if (tok_end.found) begin
          fin_rsp.status = ST_OK;
        end else if (tok_end.free_found) begin
          fin_rsp.status = ST_INSERTED;
          fin_insert     = 1'b1;
        end else begin
          fin_rsp.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (tok_end.found) begin
          fin_rsp.status            = ST_OK;
          fin_rsp.granted_mask      = tok_end.hit_mask;
          fin_rsp.remaining_seconds = tok_end.hit_remaining;
        end else begin
          fin_rsp.status = ST_NO_ENTRY;
        end
      end
      default: begin
        fin_rsp.status        = ST_OK;
        fin_rsp.removed_count = tok_end.removed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_end.active) begin
      pend_rsp    <= fin_rsp;
      ins_pending <= fin_insert;
      ins_idx     <= fidx[TableEntries];
    end
    if (move) begin
      rsp_data <= pend_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tok_end.active) begin
        pending <= 1'b1;
      end else if (move) begin
        pending <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/slt_cell.sv */
module slt_cell import slt_pkg::*; #(
  parameter int IdxW = 4,
  parameter int Index = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  req_t            cmd,
  input  logic [32:0]     lease_end,
  input  tok_t            tok_in,
  input  logic [IdxW-1:0] free_idx_in,
  output tok_t            tok_out,
  output logic [IdxW-1:0] free_idx_out,
  input  logic            ins_en,
  input  logic [IdxW-1:0] ins_idx
);

  logic        valid;
  logic [63:0] clock_identity;
  logic [15:0] port_number;
  logic [31:0] address;
  logic [63:0] mask;
  logic [32:0] expiry;

  logic        match;
  logic        mask_zero;
  logic        expired;
  logic        drop;
  logic        rewrite;
  logic        ins_here;
  logic [32:0] now_ext;
  logic [32:0] diff;
  logic [15:0] remaining;
  tok_t        tok_next;
  logic [IdxW-1:0] free_idx_next;

  assign now_ext   = {1'b0, cmd.now_seconds};
  assign match     = valid && clock_identity == cmd.requester_clock_identity
                     && port_number == cmd.requester_port_number;
  assign mask_zero = cmd.event_mask == 64'd0;
  assign expired   = expiry <= now_ext;
  assign diff      = expiry - now_ext;
  assign ins_here  = ins_en && ins_idx == IdxW'(Index);

  always_comb begin
    if (expired) begin
      remaining = 16'd0;
    end else if (|diff[32:16]) begin
      remaining = REMAINING_MAX;
    end else begin
      remaining = diff[15:0];
    end
  end

  always_comb begin
    drop    = 1'b0;
    rewrite = 1'b0;
    if (tok_in.active && valid) begin
      case (cmd.opcode)
        OP_UPDATE: begin
          drop    = match && mask_zero;
          rewrite = match && !mask_zero;
        end
        OP_PRUNE: drop = expired;
        OP_FLUSH: drop = 1'b1;
        default: begin
          drop    = 1'b0;
          rewrite = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    tok_next      = tok_in;
    free_idx_next = free_idx_in;
    if (tok_in.active) begin
      if (match) begin
        tok_next.found         = 1'b1;
        tok_next.hit_mask      = mask;
        tok_next.hit_remaining = remaining;
      end
      // lowest free slot wins
      if (!tok_in.free_found && !valid) begin
        tok_next.free_found = 1'b1;
        free_idx_next       = IdxW'(Index);
      end
      if (drop && tok_in.removed != REMOVED_MAX) begin
        tok_next.removed = tok_in.removed + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (drop) begin
      valid <= 1'b0;
    end else if (ins_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rewrite || ins_here) begin
      clock_identity <= cmd.requester_clock_identity;
      port_number    <= cmd.requester_port_number;
      address        <= cmd.return_address;
      mask           <= cmd.event_mask;
      expiry         <= lease_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    free_idx_out <= free_idx_next;
  end

  // address is held for the subscriber but not reported by any request
  logic unused_address;
  assign unused_address = ^address;

endmodule

/* sv/slt_checker.sv */
module slt_checker import slt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped or changed under backpressure");

  // only a found get carries a mask or a lease
  a_get_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.granted_mask == 64'd0 && rsp_data.remaining_seconds == 16'd0)
    else $error("mask or lease reported without a found entry");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.removed_count != 5'd0 |-> rsp_data.status == ST_OK
      && rsp_data.granted_mask == 64'd0)
    else $error("removed count on a non prune response");

endmodule

bind subscription_lease_table slt_checker u_slt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data (rsp.data)
);
